>>> hw/rtl/sodl_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register codes for the octave divider low-pass block.
package sodl_pkg;

  // Audio sample width; every sample-dependent width below follows from it.
  localparam int SAMPLE_WIDTH = 16;

  // Left shift that brings a sample to Q1.31 for the trigger compare.
  localparam int X_SHIFT = 32 - SAMPLE_WIDTH;

  // Right shift from the Q30 filter sum to the output format.
  localparam int OUT_SHIFT = (SAMPLE_WIDTH <= 31) ? (31 - SAMPLE_WIDTH) : 0;
  localparam int RND_POS   = (OUT_SHIFT > 0) ? (OUT_SHIFT - 1) : 0;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TRIP_W     = 15;
  localparam int GAIN_W     = 15;
  localparam int FB_W       = 16;
  localparam int MEM_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIP_LEVEL  = 2'd0,
    CFG_LP_GAIN     = 2'd1,
    CFG_LP_FEEDBACK = 2'd2
  } sodl_cfg_idx_e;

  localparam logic [TRIP_W-1:0]      TRIP_LEVEL_RST  = 15'd275;
  localparam logic [GAIN_W-1:0]      LP_GAIN_RST     = 15'd631;
  localparam logic signed [FB_W-1:0] LP_FEEDBACK_RST = -16'sd31506;

  typedef struct packed {
    logic [TRIP_W-1:0]      trip_level;
    logic [GAIN_W-1:0]      lp_gain;
    logic signed [FB_W-1:0] lp_feedback;
  } sodl_cfg_t;

  // Divider flip-flop levels after the current sample.
  typedef struct packed {
    logic div_two;
    logic div_four;
  } sodl_oct_t;

endpackage

>>> hw/rtl/schmitt_octave_divider_lowpass_unit.sv
`timescale 1ns / 1ps
// Top level of the Schmitt-trigger octave divider with smoothing low-pass.
//
//   Port group  Direction  Handshake                Carries
//   in          receive    in_valid_i / in_stall_o  sample_in_i
//   out         send       out_valid_o / out_stall_i sample_out_o, octave_down_one_o,
//                                                    octave_down_two_o
//   cfg         receive    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each input word is captured in an input register; from there the trigger, the
// divider flip-flops and one filter multiply-accumulate run on it and the result
// word is written to the output register. One word is taken per cycle while the
// output is not stalled, set by the single filter multiply-accumulate on its own memory.
// Reset clears the trigger, divider and filter state, the pipeline valid flags, and
// loads the register reset values. cfg_ready_o stays high.
// While a result word is stalled, a new word can still enter the input register; the
// input stalls only when both registers are full and the output is stalled.
module schmitt_octave_divider_lowpass_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [sodl_pkg::SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [sodl_pkg::SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                               octave_down_one_o,
  output logic                               octave_down_two_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sodl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sodl_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import sodl_pkg::*;

  sodl_cfg_t cfg;
  sodl_oct_t oct;

  // Input register.
  logic                           in_vld_q;
  logic [SAMPLE_WIDTH-1:0]        in_sample_q;

  // Output register.
  logic                           out_vld_q;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
  logic                           out_one_q;
  logic                           out_two_q;

  logic                           out_free;
  logic                           fire;
  logic                           in_take;
  logic signed [SAMPLE_WIDTH-1:0] filt_sample;

  // The output register can load when it is empty or its word leaves this cycle.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  sodl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sodl_trigger u_trigger (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (fire),
    .sample_i     (in_sample_q),
    .trip_level_i (cfg.trip_level),
    .oct_o        (oct)
  );

  // The filter sees +1 when the divide-by-two flip-flop is high, -1 otherwise.
  sodl_filter u_filter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (fire),
    .polarity_i    (oct.div_two),
    .lp_gain_i     (cfg.lp_gain),
    .lp_feedback_i (cfg.lp_feedback),
    .sample_o      (filt_sample)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_sample_q <= sample_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_sample_q <= filt_sample;
      out_one_q    <= oct.div_two;
      out_two_q    <= oct.div_four;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign sample_out_o      = out_sample_q;
  assign octave_down_one_o = out_one_q;
  assign octave_down_two_o = out_two_q;

endmodule

>>> hw/rtl/sodl_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file for the octave divider low-pass block.
module sodl_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sodl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sodl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output sodl_pkg::sodl_cfg_t             cfg_o
);
  import sodl_pkg::*;

  sodl_cfg_t cfg_q, cfg_d;

  // Writes are always taken; an index beyond the list is dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TRIP_LEVEL:  cfg_d.trip_level  = cfg_data_i[TRIP_W-1:0];
        CFG_LP_GAIN:     cfg_d.lp_gain     = cfg_data_i[GAIN_W-1:0];
        CFG_LP_FEEDBACK: cfg_d.lp_feedback = $signed(cfg_data_i[FB_W-1:0]);
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trip_level  <= TRIP_LEVEL_RST;
      cfg_q.lp_gain     <= LP_GAIN_RST;
      cfg_q.lp_feedback <= LP_FEEDBACK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/sodl_trigger.sv
`timescale 1ns / 1ps
// Schmitt trigger with the divide-by-two and divide-by-four flip-flops.
module sodl_trigger (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [sodl_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic [sodl_pkg::TRIP_W-1:0]       trip_level_i,
  output sodl_pkg::sodl_oct_t               oct_o
);
  import sodl_pkg::*;

  logic               level_q, level_d;
  logic               div2_q, div2_d;
  logic               div4_q, div4_d;
  logic signed [32:0] x31;
  logic signed [32:0] trip31;
  logic               rising;

  always_comb begin
    x31    = $signed({{(33 - SAMPLE_WIDTH){sample_i[SAMPLE_WIDTH-1]}}, sample_i}) <<< X_SHIFT;
    trip31 = $signed({2'b00, trip_level_i, 16'd0});
    // Inside the band, the edges included, the level holds.
    if (x31 > trip31) begin
      level_d = 1'b1;
    end else if (x31 < -trip31) begin
      level_d = 1'b0;
    end else begin
      level_d = level_q;
    end
    rising = level_d & ~level_q;
    div2_d = div2_q ^ rising;
    // The second stage toggles when the first one falls.
    div4_d = div4_q ^ (rising & div2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      div2_q  <= 1'b0;
      div4_q  <= 1'b0;
    end else if (en_i) begin
      level_q <= level_d;
      div2_q  <= div2_d;
      div4_q  <= div4_d;
    end
  end

  assign oct_o.div_two  = div2_d;
  assign oct_o.div_four = div4_d;

endmodule

>>> hw/rtl/sodl_filter.sv
`timescale 1ns / 1ps
// First-order transposed low-pass on the square wave, with saturating memory.
module sodl_filter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  polarity_i,
  input  logic [sodl_pkg::GAIN_W-1:0]           lp_gain_i,
  input  logic signed [sodl_pkg::FB_W-1:0]      lp_feedback_i,
  output logic signed [sodl_pkg::SAMPLE_WIDTH-1:0] sample_o
);
  import sodl_pkg::*;

  localparam logic signed [35:0] MEM_MAX = 36'sd2147483647;
  localparam logic signed [35:0] MEM_MIN = -36'sd2147483648;
  localparam logic signed [34:0] RES_MAX = (35'sd1 <<< (SAMPLE_WIDTH - 1)) - 35'sd1;
  localparam logic signed [34:0] RES_MIN = -(35'sd1 <<< (SAMPLE_WIDTH - 1));
  localparam logic signed [34:0] RES_BIAS = (OUT_SHIFT > 0) ? (35'sd1 <<< RND_POS) : 35'sd0;

  logic signed [MEM_W-1:0] mem_q, mem_d;
  logic signed [32:0]      ff;
  logic signed [32:0]      y30;
  logic signed [48:0]      prod;
  logic signed [33:0]      fb;
  logic signed [35:0]      mem_full;
  logic signed [34:0]      y_ext;
  logic signed [34:0]      res;

  always_comb begin
    ff = $signed({3'b000, lp_gain_i, 15'd0});
    if (!polarity_i) begin
      ff = -ff;
    end
    y30  = ff + 33'(mem_q);
    prod = 49'(lp_feedback_i) * 49'(y30);
    // Feedback term rounded half up to Q30.
    fb       = 34'((prod + 49'sd16384) >>> 15);
    mem_full = 36'(ff) - 36'(fb);
    if (mem_full > MEM_MAX) begin
      mem_d = MEM_MAX[MEM_W-1:0];
    end else if (mem_full < MEM_MIN) begin
      mem_d = MEM_MIN[MEM_W-1:0];
    end else begin
      mem_d = mem_full[MEM_W-1:0];
    end

    y_ext = 35'(y30);
    if (SAMPLE_WIDTH <= 31) begin
      res = (y_ext + RES_BIAS) >>> OUT_SHIFT;
    end else begin
      res = y_ext <<< 1;
    end
    if (res > RES_MAX) begin
      res = RES_MAX;
    end else if (res < RES_MIN) begin
      res = RES_MIN;
    end
    sample_o = res[SAMPLE_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_q <= '0;
    end else if (en_i) begin
      mem_q <= mem_d;
    end
  end

endmodule

>>> hw/rtl/sodl_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the octave divider low-pass block, with its bind.
module sodl_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [sodl_pkg::SAMPLE_WIDTH-1:0] sample_out_o,
  input logic                              octave_down_one_o,
  input logic                              octave_down_two_o
);
  import sodl_pkg::*;

  // A stalled result word stays valid.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sample_out_o) && $stable(octave_down_one_o)
      && $stable(octave_down_two_o))
    else $error("result payload changed while stalled");

  // The input side stalls only behind a stalled, full output.
  a_in_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A result after an empty output only comes straight from a newly taken input word.
  a_out_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result word without a matching input word");

endmodule

bind schmitt_octave_divider_lowpass_unit sodl_checker u_sodl_checker (.*);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Schmitt-trigger octave divider with smoothing low-pass.
module testbench;
  import sodl_pkg::*;

  // Sample range in the block's own format.
  localparam int SMAX = (1 << (SAMPLE_WIDTH - 1)) - 1;
  localparam int SMIN = -(1 << (SAMPLE_WIDTH - 1));

  // The register list has three entries, so the last code of the index field
  // addresses nothing and a write to it must leave every register alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // The predictor prints at most this many mismatch lines but counts them all.
  localparam int REPORT_LINES = 100;

  // Word of results that one sample produces.
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           down_one;
    logic                           down_two;
  } octave_word_t;

  // Tracks the trigger, both divider flip-flops and the filter memory of the block,
  // works out the word that each accepted sample must produce and holds those words
  // in order until the block returns them.
  class octave_lowpass_tracker;
    logic [TRIP_W-1:0]      trip_level;
    logic [GAIN_W-1:0]      lp_gain;
    logic signed [FB_W-1:0] lp_feedback;
    bit                     trigger_high;
    bit                     div_two;
    bit                     div_four;
    longint                 filter_mem;
    octave_word_t           awaited_words[$];
    int                     fails;

    function new();
      trip_level   = TRIP_LEVEL_RST;
      lp_gain      = LP_GAIN_RST;
      lp_feedback  = LP_FEEDBACK_RST;
      trigger_high = 1'b0;
      div_two      = 1'b0;
      div_four     = 1'b0;
      filter_mem   = 0;
      fails        = 0;
    endfunction

    task report(input string msg);
      if (fails < REPORT_LINES) $display("[%0t] mismatch: %s", $realtime, msg);
      fails++;
    endtask

    // Bits above a register's width are dropped; the spare index changes nothing.
    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TRIP_LEVEL:  trip_level  = data[TRIP_W-1:0];
        CFG_LP_GAIN:     lp_gain     = data[GAIN_W-1:0];
        CFG_LP_FEEDBACK: lp_feedback = data[FB_W-1:0];
        default: ;
      endcase
    endfunction

    // Shift right by n with rounding half up.
    function longint round_shift(input longint v, input int n);
      if (n == 0) return v;
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void take_sample(input logic signed [SAMPLE_WIDTH-1:0] smp);
      longint       x31;
      longint       trip31;
      longint       ff;
      longint       y30;
      longint       fb;
      longint       res;
      bit           level;
      octave_word_t w;
      x31    = longint'(smp) * (longint'(1) << X_SHIFT);
      trip31 = longint'(trip_level) * 65536;
      // A sample exactly on either switching level keeps the present level.
      if (x31 > trip31) level = 1'b1;
      else if (x31 < -trip31) level = 1'b0;
      else level = trigger_high;
      if (level && !trigger_high) begin
        div_two = !div_two;
        if (!div_two) div_four = !div_four;
      end
      trigger_high = level;
      // Square wave of plus or minus one, scaled by the gain into Q30.
      ff = longint'(lp_gain) * 32768;
      if (!div_two) ff = -ff;
      y30 = ff + filter_mem;
      fb  = round_shift(longint'(lp_feedback) * y30, 15);
      // The memory saturates rather than wrapping.
      filter_mem = clip(ff - fb, -(longint'(1) << 31), (longint'(1) << 31) - 1);
      if (SAMPLE_WIDTH <= 31) res = round_shift(y30, OUT_SHIFT);
      else res = y30 * 2;
      res = clip(res, SMIN, SMAX);
      w.sample_out = res[SAMPLE_WIDTH-1:0];
      w.down_one   = div_two;
      w.down_two   = div_four;
      awaited_words.push_back(w);
    endfunction

    task check_word(input logic signed [SAMPLE_WIDTH-1:0] smp,
                    input logic one, input logic two);
      octave_word_t w;
      if (awaited_words.size() == 0) begin
        report($sformatf("word returned with none awaited (sample_out %0d)", smp));
      end else begin
        w = awaited_words.pop_front();
        if (smp !== w.sample_out)
          report($sformatf("sample_out %0d, predicted %0d", smp, w.sample_out));
        if (one !== w.down_one)
          report($sformatf("octave_down_one %b, predicted %b", one, w.down_one));
        if (two !== w.down_two)
          report($sformatf("octave_down_two %b, predicted %b", two, w.down_two));
      end
    endtask
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic signed [SAMPLE_WIDTH-1:0] sample_in_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_o;
  logic                           octave_down_one_o;
  logic                           octave_down_two_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [CFG_IDX_W-1:0]           cfg_index_i;
  logic [CFG_DATA_W-1:0]          cfg_data_i;

  octave_lowpass_tracker tracker;

  // When set, the matching side stops idling so that words flow back to back.
  bit sender_calm;
  bit receiver_calm;

  // Direction of the current swing of the synthetic waveform.
  bit swing_up;

  schmitt_octave_divider_lowpass_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_in_i       (sample_in_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sample_out_o      (sample_out_o),
    .octave_down_one_o (octave_down_one_o),
    .octave_down_two_o (octave_down_two_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // Free-running clock with a 10 ns period.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Every input is given a known value at time zero. Reset is held low from the start
  // and released on a rising edge, once and for the whole run.
  initial begin
    tracker       = new();
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    swing_up      = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    sample_in_i <= '0;
    out_stall_i <= 1'b1;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_TRIP_LEVEL;
    cfg_data_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // A hard ceiling on the run. The slowest correct run, some 1300 words, ends well
  // under half a millisecond.
  initial begin
    #3ms;
    $display("testbench NOT OK");
    $finish;
  end

  // Watches all three channels. Values are read as they stood just before the edge,
  // since every driver in this bench and every register in the block changes them
  // through nonblocking updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) tracker.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) tracker.take_sample(sample_in_i);
      if (out_valid_o && !out_stall_i)
        tracker.check_word(sample_out_o, octave_down_one_o, octave_down_two_o);
    end
  end

  // The receiving side holds off each word for a random number of cycles, unless it
  // is in a calm stretch, and then takes the next word that shows up.
  initial begin
    int hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      hold = receiver_calm ? 0 : $urandom_range(0, 13);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offers one sample after a random gap and returns on the edge that takes it.
  // The valid stays high afterwards, so a following sample with no gap goes out
  // back to back; the next gap or a drain lowers it.
  task automatic send_sample(input int value);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= SAMPLE_WIDTH'(value);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops sending and waits until every awaited word has come back. Each sample
  // gives exactly one word, so after that the two-stage pipeline holds nothing
  // in flight.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.awaited_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One register write; the valid is dropped after each write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Brings the block to rest and loads a fresh setting of all three registers.
  task automatic load_setting(input logic [CFG_DATA_W-1:0] trip,
                              input logic [CFG_DATA_W-1:0] gain,
                              input logic [CFG_DATA_W-1:0] fb);
    drain_block();
    write_reg(CFG_TRIP_LEVEL, trip);
    write_reg(CFG_LP_GAIN, gain);
    write_reg(CFG_LP_FEEDBACK, fb);
  endtask

  // Picks a sample around the current switching level. Four samples in ten follow a
  // square-like swing that crosses the band both ways, so the trigger fires and
  // both divider stages keep moving; the rest are values on and next to each
  // switching level, values inside the band, full-scale extremes and plain noise.
  // The trip level is Q1.15, which matches the sample scale at this width.
  function automatic int next_sample(input int trip);
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = int'($urandom_range(0, SMAX - SMIN)) + SMIN;
      2: v = trip + int'($urandom_range(0, 2)) - 1;
      3: v = -trip + int'($urandom_range(0, 2)) - 1;
      4: v = ($urandom_range(0, 1) != 0) ? SMAX : SMIN;
      5: v = int'($urandom_range(0, 2 * trip)) - trip;
      default: begin
        if ($urandom_range(0, 2) == 0) swing_up = !swing_up;
        if (swing_up) v = trip + int'($urandom_range(0, SMAX - trip));
        else v = -trip - int'($urandom_range(0, -SMIN - trip));
      end
    endcase
    if (v > SMAX) v = SMAX;
    if (v < SMIN) v = SMIN;
    return v;
  endfunction

  // Sends a run of random samples; halfway through, if asked, the sender stops
  // until every awaited word has come back before going on.
  task automatic random_run(input int count, input bit pause_midway);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) drain_block();
      send_sample(next_sample(int'(tracker.trip_level)));
    end
  endtask

  // Stimulus: first the reset values of the registers with hand-picked samples,
  // then a series of register settings, each followed by a run of random samples.
  initial begin
    int settle;
    wait (rst_ni);
    @(posedge clk_i);

    // Reset values, switching level 275. Samples sit on each level, just past it,
    // at full scale and on alternating bit patterns, which together walk both
    // divider stages through all four states.
    send_sample(0);
    send_sample(275);
    send_sample(276);
    send_sample(275);
    send_sample(-275);
    send_sample(-276);
    send_sample(SMAX);
    send_sample(SMIN);
    send_sample(int'(16'sh5555));
    send_sample(int'(16'shAAAA));
    send_sample(SMAX);
    send_sample(-1);
    send_sample(SMIN);
    send_sample(1000);
    send_sample(-1000);
    send_sample(1);
    send_sample(SMAX);

    // Extremes: a zero switching level written with its unused top bit set, full
    // gain and the most negative feedback, which drives the filter memory into
    // saturation. A zero sample then sits exactly on both levels at once. The
    // spare register index is written as well and must change nothing.
    load_setting(16'h8000, 16'h7FFF, 16'h8000);
    write_reg(CFG_SPARE_IDX, 16'(  $urandom_range(0, 65535)));
    send_sample(0);
    send_sample(1);
    send_sample(0);
    send_sample(-1);
    send_sample(0);
    send_sample(1);
    send_sample(SMAX);
    random_run(200, 1'b0);

    // Opposite extremes: the widest band (a write of all ones, top bit dropped),
    // zero gain written with its top bit set, and the largest positive feedback.
    sender_calm = 1'b1;
    load_setting(16'hFFFF, 16'h8000, 16'h7FFF);
    random_run(200, 1'b0);

    // Random setting, with the sender pausing halfway for every word to return.
    sender_calm   = 1'b0;
    receiver_calm = 1'b1;
    load_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
    random_run(210, 1'b1);

    // Reset values written back, with neither side idling.
    sender_calm = 1'b1;
    load_setting(16'(TRIP_LEVEL_RST), 16'(LP_GAIN_RST), LP_FEEDBACK_RST);
    random_run(210, 1'b0);

    // A narrow band with a damping negative feedback, as the block is meant to run.
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    load_setting(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 65535)),
                 16'(-$urandom_range(1, 32768)));
    write_reg(CFG_SPARE_IDX, 16'($urandom_range(0, 65535)));
    random_run(220, 1'b0);

    // Fully random settings, with the idling of each side drawn at random.
    for (int p = 0; p < 2; p++) begin
      sender_calm   = ($urandom_range(0, 3) == 0);
      receiver_calm = ($urandom_range(0, 3) == 0);
      load_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
      random_run(110, 1'b0);
    end

    // Wind down: wait, with a limit, for the last words, then keep watching in case the
    // block sends anything it should not.
    in_valid_i <= 1'b0;
    settle = 0;
    while (tracker.awaited_words.size() != 0 && settle < 2000) begin
      @(posedge clk_i);
      settle++;
    end
    repeat (10) @(posedge clk_i);
    if (tracker.awaited_words.size() != 0)
      tracker.report($sformatf("%0d words never returned", tracker.awaited_words.size()));

    if (tracker.fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
